@@ hw/rtl/plcd_pkg.sv @@
// Shared types and constants for the parallel LCD window writer.
package plcd_pkg;

	// Item kinds
	localparam logic [1:0] FUNC_COMMAND = 2'd0;
	localparam logic [1:0] FUNC_DATA    = 2'd1;
	localparam logic [1:0] FUNC_WINDOW  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_COLUMN_CMD   = 2'd0;
	localparam logic [1:0] CFG_ROW_CMD      = 2'd1;
	localparam logic [1:0] CFG_MEMWRITE_CMD = 2'd2;

	// Reset values of the command registers
	localparam logic [7:0] COLUMN_CMD_RST   = 8'd42;
	localparam logic [7:0] ROW_CMD_RST      = 8'd43;
	localparam logic [7:0] MEMWRITE_CMD_RST = 8'd44;

	// Window burst steps: column command plus four bytes, row command plus four
	// bytes, then the memory-write command.
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_COL_CMD   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_COL_FHI   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_COL_FLO   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_COL_SHI   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_COL_SLO   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_ROW_CMD   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_ROW_FHI   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_ROW_FLO   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ROW_SHI   = 4'd8;
	localparam logic [STEP_W-1:0] STEP_ROW_SLO   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_MEMWR_CMD = 4'd10;

	typedef struct packed {
		logic [15:0] left;
		logic [15:0] right;
		logic [15:0] top;
		logic [15:0] bottom;
	} window_t;

	typedef struct packed {
		logic [7:0] column_cmd;
		logic [7:0] row_cmd;
		logic [7:0] memwrite_cmd;
	} cmd_cfg_t;

	typedef struct packed {
		logic col_chg;
		logic row_chg;
	} plan_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       dc_level;
		logic       last;
	} beat_t;

endpackage

@@ hw/rtl/plcd_cache.sv @@
// Cached column/row ranges and the compare against the pending window.
module plcd_cache import plcd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  window_t win,
	input  logic    update,
	output plan_t   plan
);

	window_t cache_q;

	always_comb begin
		plan.col_chg = (cache_q.left != win.left) || (cache_q.right != win.right);
		plan.row_chg = (cache_q.top != win.top) || (cache_q.bottom != win.bottom);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_q <= '0;
		end else if (update) begin
			if (plan.col_chg) begin
				cache_q.left  <= win.left;
				cache_q.right <= win.right;
			end
			if (plan.row_chg) begin
				cache_q.top    <= win.top;
				cache_q.bottom <= win.bottom;
			end
		end
	end

endmodule

@@ hw/rtl/plcd_burst.sv @@
// Beat sequencer: turns the held item into one bus write per cycle while the output register is free.
module plcd_burst import plcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] func,
	input  logic [7:0] byte_value,
	input  logic       write_request,
	input  window_t    win,
	input  plan_t      plan,
	input  cmd_cfg_t   cmds,
	input  logic       advance,
	output logic       has_beats,
	output beat_t      beat
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step;
	logic [STEP_W-1:0] step_nxt;
	logic              is_window;

	assign is_window = (func == FUNC_WINDOW) && write_request;
	assign has_beats = (func == FUNC_COMMAND) || (func == FUNC_DATA) || is_window;

	// step_q == 0 means a fresh item: skip ranges that match the cache
	always_comb begin
		if (step_q == STEP_COL_CMD) begin
			if (plan.col_chg) begin
				step = STEP_COL_CMD;
			end else if (plan.row_chg) begin
				step = STEP_ROW_CMD;
			end else begin
				step = STEP_MEMWR_CMD;
			end
		end else begin
			step = step_q;
		end
	end

	always_comb begin
		if (step == STEP_COL_SLO) begin
			step_nxt = plan.row_chg ? STEP_ROW_CMD : STEP_MEMWR_CMD;
		end else begin
			step_nxt = step + 1'b1;
		end
	end

	always_comb begin
		beat.last = 1'b1;
		if (func == FUNC_COMMAND) begin
			beat.bus_byte = byte_value;
			beat.dc_level = 1'b0;
		end else if (func == FUNC_DATA) begin
			beat.bus_byte = byte_value;
			beat.dc_level = 1'b1;
		end else begin
			beat.dc_level = 1'b1;
			beat.last     = 1'b0;
			case (step)
				STEP_COL_CMD: begin
					beat.bus_byte = cmds.column_cmd;
					beat.dc_level = 1'b0;
				end
				STEP_COL_FHI: beat.bus_byte = win.left[15:8];
				STEP_COL_FLO: beat.bus_byte = win.left[7:0];
				STEP_COL_SHI: beat.bus_byte = win.right[15:8];
				STEP_COL_SLO: beat.bus_byte = win.right[7:0];
				STEP_ROW_CMD: begin
					beat.bus_byte = cmds.row_cmd;
					beat.dc_level = 1'b0;
				end
				STEP_ROW_FHI: beat.bus_byte = win.top[15:8];
				STEP_ROW_FLO: beat.bus_byte = win.top[7:0];
				STEP_ROW_SHI: beat.bus_byte = win.bottom[15:8];
				STEP_ROW_SLO: beat.bus_byte = win.bottom[7:0];
				default: begin
					beat.bus_byte = cmds.memwrite_cmd;
					beat.dc_level = 1'b0;
					beat.last     = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_COL_CMD;
		end else if (advance && has_beats) begin
			step_q <= beat.last ? STEP_COL_CMD : step_nxt;
		end
	end

endmodule

@@ hw/rtl/parallel_lcd_window_writer.sv @@
// Top level of the 8080-style LCD write front end.
//
//  channel   dir   handshake            payload
//  in        in    in_valid/in_ready    func byte_value left right top bottom write_request
//  out       out   out_valid/out_ready  bus_byte dc_level last
//  cfg       in    cfg_we               cfg_index cfg_data
//
// Command and data items are one bus beat each and can follow back to back.
// A window write item gives 1 to 11 bus beats, set by the beat
// sequencer; input is held off during the burst.
// Reset clears the range cache and loads the default command bytes.
// The output register stalls on out_ready low; the input stage then fills and stalls.
module parallel_lcd_window_writer import plcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  byte_value,
	input  logic [15:0] left,
	input  logic [15:0] right,
	input  logic [15:0] top,
	input  logic [15:0] bottom,
	input  logic        write_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  bus_byte,
	output logic        dc_level,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cmd_cfg_t   cmds_q;
	logic       valid_s1;
	logic [1:0] func_s1;
	logic [7:0] byte_s1;
	logic       wr_s1;
	window_t    win_s1;
	plan_t      plan;
	beat_t      beat;
	beat_t      out_q;
	logic       has_beats;
	logic       out_free;
	logic       advance;
	logic       retire;
	logic       cache_upd;

	assign out_free  = !out_valid || out_ready;
	assign advance   = valid_s1 && out_free;
	// beatless items (read window, unused kind) drop out right away
	assign retire    = valid_s1 && (!has_beats || (out_free && beat.last));
	assign cache_upd = retire && (func_s1 == FUNC_WINDOW) && wr_s1;
	assign in_ready  = !valid_s1 || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmds_q.column_cmd   <= COLUMN_CMD_RST;
			cmds_q.row_cmd      <= ROW_CMD_RST;
			cmds_q.memwrite_cmd <= MEMWRITE_CMD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMN_CMD:   cmds_q.column_cmd   <= cfg_data;
				CFG_ROW_CMD:      cmds_q.row_cmd      <= cfg_data;
				CFG_MEMWRITE_CMD: cmds_q.memwrite_cmd <= cfg_data;
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1       <= func;
			byte_s1       <= byte_value;
			wr_s1         <= write_request;
			win_s1.left   <= left;
			win_s1.right  <= right;
			win_s1.top    <= top;
			win_s1.bottom <= bottom;
		end
	end

	plcd_cache u_cache (
		.clk    (clk),
		.arst_n (arst_n),
		.win    (win_s1),
		.update (cache_upd),
		.plan   (plan)
	);

	plcd_burst u_burst (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func_s1),
		.byte_value    (byte_s1),
		.write_request (wr_s1),
		.win           (win_s1),
		.plan          (plan),
		.cmds          (cmds_q),
		.advance       (advance),
		.has_beats     (has_beats),
		.beat          (beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1 && has_beats;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_beats) begin
			out_q <= beat;
		end
	end

	assign bus_byte = out_q.bus_byte;
	assign dc_level = out_q.dc_level;
	assign last     = out_q.last;

endmodule
